[src/mocf_pkg.sv]
package mocf_pkg;

  // Field widths fixed by the interface.
  localparam int OFS_W = 32;
  localparam int MAG_W = 31;
  localparam int TOL_W = 4;
  localparam int PROD_W = MAG_W + TOL_W;

  // Bit counter for the serial median search, counts MAG_W-1 down to 0.
  localparam int BIT_CW = $clog2(MAG_W);

  localparam int WINDOW_DEF = 10;
  localparam logic [TOL_W-1:0] TOL_RESET = 4'd5;
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
  localparam logic [OFS_W-1:0] OFS_MIN = {1'b1, {(OFS_W-1){1'b0}}};

  // Controls from the sequencer to the window storage.
  typedef struct packed {
    logic write;
    logic rotate;
  } mocf_win_ctrl_t;

  // Status of the serial median search.
  typedef struct packed {
    logic busy;
    logic done;
  } mocf_sel_stat_t;

  // Magnitude of a two's complement offset; the most negative value saturates.
  function automatic logic [MAG_W-1:0] magnitude_of(input logic [OFS_W-1:0] v);
    logic [OFS_W-1:0] neg;
    neg = ~v + {{(OFS_W-1){1'b0}}, 1'b1};
    if (!v[OFS_W-1]) begin
      return v[MAG_W-1:0];
    end else if (v == OFS_MIN) begin
      return MAG_MAX;
    end else begin
      return neg[MAG_W-1:0];
    end
  endfunction

endpackage

[src/mocf_window.sv]
module mocf_window #(
  parameter int WINDOW = mocf_pkg::WINDOW_DEF
) (
  input  logic                         clk,
  input  mocf_pkg::mocf_win_ctrl_t     ctrl,
  input  logic [$clog2(WINDOW)-1:0]    wr_pos,
  input  logic [mocf_pkg::MAG_W-1:0]   wr_mag,
  output logic [WINDOW-1:0]            msb
);
  import mocf_pkg::*;

  localparam int PW = $clog2(WINDOW);

  // Each entry is a circular shift register. During the median search all
  // entries rotate left together, so their top bits present one bit plane
  // per cycle, most significant first. After MAG_W rotations every entry is
  // back in its original alignment.
  for (genvar i = 0; i < WINDOW; i++) begin : g_entry
    logic [MAG_W-1:0] entry;

    always_ff @(posedge clk) begin
      if (ctrl.write && (wr_pos == PW'(i))) begin
        entry <= wr_mag;
      end else if (ctrl.rotate) begin
        entry <= {entry[MAG_W-2:0], entry[MAG_W-1]};
      end
    end

    assign msb[i] = entry[MAG_W-1];
  end

endmodule

[src/mocf_select.sv]
module mocf_select #(
  parameter int WINDOW = mocf_pkg::WINDOW_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [WINDOW-1:0]            msb,
  output mocf_pkg::mocf_sel_stat_t     stat,
  output logic [mocf_pkg::MAG_W-1:0]   median
);
  import mocf_pkg::*;

  localparam int KW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam logic [KW-1:0] RANK0 = KW'((WINDOW - 1) / 2);

  logic              busy;
  logic              done;
  logic [WINDOW-1:0] cand;
  logic [KW-1:0]     rank;
  logic [BIT_CW-1:0] cnt;
  logic [MAG_W-1:0]  med;

  logic [WINDOW-1:0] zeros;
  logic [CW-1:0]     zero_cnt;
  logic              take_zero;

  // Candidates whose current bit is zero, and how many of them there are.
  always_comb begin
    zeros = cand & ~msb;
    zero_cnt = '0;
    for (int i = 0; i < WINDOW; i++) begin
      zero_cnt = zero_cnt + CW'(zeros[i]);
    end
  end

  // If more candidates than the wanted rank have a zero here, the median
  // has a zero in this bit and the ones drop out; otherwise the zeros drop
  // out and the rank moves past them.
  assign take_zero = zero_cnt > CW'(rank);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cand <= '1;
      rank <= RANK0;
      cnt  <= BIT_CW'(MAG_W - 1);
    end else if (busy) begin
      med <= {med[MAG_W-2:0], ~take_zero};
      if (take_zero) begin
        cand <= zeros;
      end else begin
        cand <= cand & msb;
        rank <= rank - KW'(zero_cnt);
      end
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - BIT_CW'(1);
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign median    = med;

  // The wanted rank always lies inside the surviving candidate set.
  a_rank_in_set: assert property (@(posedge clk) disable iff (rst)
    busy |-> (int'(rank) < $countones(cand)))
    else $error("median rank fell outside the candidate set");

endmodule

[src/median_outlier_clock_filter_top.sv]
// Median outlier filter for clock offsets.
// Input channel: offset_value with in_valid / in_stall; a word is taken at a
// clock edge with in_valid high and in_stall low. Output channel: accepted,
// window_median and window_full with out_valid / out_stall, one result word
// for every input word, in order.
// Configuration: tolerance_factor is written with cfg_valid / cfg_ready; the
// user must do so only while the block is idle, which the block itself does
// not enforce. cfg_ready is always high. Reset value is 5.
// While the window is filling, the result word goes through S_OUT into the
// output register; the next input word can be taken as soon as that result
// word can. Once the window is full, the lower median is found one bit plane
// per cycle over all MAG_W = 31 bit planes, then multiplied and compared; no
// new input word is taken until that result word has moved out.
// Synchronous reset (rst) clears the fill count, rewinds the write slot and
// restores the tolerance; a word still in flight at reset is dropped.
// If the receiver stalls, the result word holds on the output; one further
// finished result may wait inside while the block stops taking input.
module median_outlier_clock_filter_top #(
  parameter int WINDOW = mocf_pkg::WINDOW_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mocf_pkg::OFS_W-1:0]   offset_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         accepted,
  output logic [mocf_pkg::MAG_W-1:0]   window_median,
  output logic                         window_full,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mocf_pkg::TOL_W-1:0]   tolerance_factor
);
  import mocf_pkg::*;

  localparam int PW = $clog2(WINDOW);
  localparam int FW = $clog2(WINDOW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEL  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]        state;
  logic [PW-1:0]     wpos;
  logic [FW-1:0]     fill;
  logic [TOL_W-1:0]  tol;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic              res_keep;
  logic [MAG_W-1:0]  res_med;
  logic              res_full;

  logic              in_accept;
  logic [MAG_W-1:0]  mag_in;
  logic [FW-1:0]     fill_next;
  logic              full_next;
  logic [PW-1:0]     wpos_next;
  logic              out_load;

  mocf_win_ctrl_t    win_ctrl;
  mocf_sel_stat_t    sel_stat;
  logic [WINDOW-1:0] plane;
  logic [MAG_W-1:0]  sel_med;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign mag_in    = magnitude_of(offset_value);

  // The fill count saturates at the window size; the write slot wraps.
  assign fill_next = (fill == FW'(WINDOW)) ? fill : fill + FW'(1);
  assign full_next = (fill_next == FW'(WINDOW));
  assign wpos_next = (wpos == PW'(WINDOW - 1)) ? '0 : wpos + PW'(1);

  assign win_ctrl.write  = in_accept;
  assign win_ctrl.rotate = sel_stat.busy;

  // The result word moves out once the output register is free or drained.
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  mocf_window #(.WINDOW(WINDOW)) u_window (
    .clk    (clk),
    .ctrl   (win_ctrl),
    .wr_pos (wpos),
    .wr_mag (mag_in),
    .msb    (plane)
  );

  mocf_select #(.WINDOW(WINDOW)) u_select (
    .clk    (clk),
    .rst    (rst),
    .start  (in_accept && full_next),
    .msb    (plane),
    .stat   (sel_stat),
    .median (sel_med)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wpos  <= '0;
      fill  <= '0;
      tol   <= TOL_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tol <= tolerance_factor;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            wpos <= wpos_next;
            fill <= fill_next;
            mag  <= mag_in;
            if (full_next) begin
              state <= S_SEL;
            end else begin
              res_keep <= 1'b1;
              res_med  <= '0;
              res_full <= 1'b0;
              state    <= S_OUT;
            end
          end
        end
        S_SEL: begin
          if (sel_stat.done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PROD_W'(tol) * PROD_W'(sel_med);
          state <= S_CMP;
        end
        S_CMP: begin
          res_keep <= (PROD_W'(mag) <= prod);
          res_med  <= sel_med;
          res_full <= 1'b1;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      accepted      <= res_keep;
      window_median <= res_med;
      window_full   <= res_full;
    end
  end

  // A result from a window still filling is always kept with a zero median.
  a_fill_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !window_full) |-> (accepted && (window_median == '0)))
    else $error("filling window produced a rejection or a median");

  // The fill count never passes the window size.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(WINDOW))
    else $error("fill count overran the window");

  // While waiting on the median search, the search is running or finishing.
  a_sel_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEL) |-> (sel_stat.busy || sel_stat.done))
    else $error("median search stopped while the sequencer waits");

endmodule

[sim/tb_median_outlier_clock_filter_top.sv]
module tb_median_outlier_clock_filter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mocf_pkg::*;

  // The block is built with its default window. MID_RANK is the sorted position
  // of the lower median.
  localparam int WIN = WINDOW_DEF;
  localparam int MID_RANK = (WIN - 1) / 2;
  localparam int PHASES = 10;
  localparam int PHASE_WORDS = 163;

  // The slowest correct run is about 1650 words, each taking the block's full
  // processing time plus the longest input gap and the longest output stall.
  // The limit below is several times that.
  localparam int CYCLE_LIMIT = 1_000_000;

  // The receiver holds off this long once, so that the block fills up and
  // stalls its input while words keep being offered.
  localparam int HOLD_CYCLES = 300;

  // Filter state as the block should hold it: the stored magnitudes, the slot
  // written next, the fill count and the tolerance in force.
  typedef struct packed {
    logic [WIN-1:0][MAG_W-1:0] mag;
    logic [7:0]                slot;
    logic [7:0]                fill;
    logic [TOL_W-1:0]          tol;
  } filter_state_t;

  // One result word, laid out like the output ports.
  typedef struct packed {
    logic             accepted;
    logic [MAG_W-1:0] median;
    logic             full;
  } filter_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [OFS_W-1:0] offset_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             accepted;
  logic [MAG_W-1:0] window_median;
  logic             window_full;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [TOL_W-1:0] tolerance_factor = '0;

  // model_st follows the words the block has actually taken. plan_st runs
  // ahead over the words queued for sending, so that the stimulus can aim
  // offsets right at the rejection threshold.
  filter_state_t model_st;
  filter_state_t plan_st;

  logic [OFS_W-1:0] offsets_to_send[$];
  filter_result_t   expected_verdicts[$];

  int  cycle_count = 0;
  int  mismatches = 0;
  int  offsets_taken = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  word_taken = 1'b0;
  bit  calm = 1'b0;
  bit  long_hold = 1'b0;
  logic [MAG_W-1:0] ofs_scale = 31'd1000;

  median_outlier_clock_filter_top #(
    .WINDOW(WIN)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .offset_value     (offset_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .accepted         (accepted),
    .window_median    (window_median),
    .window_full      (window_full),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .tolerance_factor (tolerance_factor)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Magnitude of a two's complement offset. The most negative offset has no
  // positive counterpart in 32 bits, so it saturates to the largest magnitude.
  function automatic logic [MAG_W-1:0] offset_magnitude(input logic [OFS_W-1:0] v);
    logic [OFS_W-1:0] neg;
    neg = -v;
    if (!v[OFS_W-1]) return v[MAG_W-1:0];
    if (v == OFS_MIN) return MAG_MAX;
    return neg[MAG_W-1:0];
  endfunction

  // Lower median by rank: the entry with at most MID_RANK entries strictly
  // below it and more than MID_RANK entries at or below it. Ties are handled
  // because any copy of the tied value qualifies.
  function automatic logic [MAG_W-1:0] lower_median(input logic [WIN-1:0][MAG_W-1:0] w);
    int below;
    int not_above;
    for (int i = 0; i < WIN; i++) begin
      below = 0;
      not_above = 0;
      for (int j = 0; j < WIN; j++) begin
        if (w[j] < w[i]) below++;
        if (w[j] <= w[i]) not_above++;
      end
      if (below <= MID_RANK && MID_RANK < not_above) return w[i];
    end
    return '0;
  endfunction

  // Takes one offset into the window and works out the result word it causes.
  // The threshold product is formed in 64 bits so it can never wrap.
  function automatic filter_result_t filter_step(inout filter_state_t st,
                                                 input logic [OFS_W-1:0] ofs);
    filter_result_t r;
    logic [MAG_W-1:0] m;
    logic [63:0] limit;
    m = offset_magnitude(ofs);
    st.mag[st.slot] = m;
    st.slot = (st.slot == WIN - 1) ? 8'd0 : st.slot + 8'd1;
    if (st.fill < WIN) st.fill = st.fill + 8'd1;
    r.full = (st.fill == WIN);
    r.median = '0;
    r.accepted = 1'b1;
    if (r.full) begin
      r.median = lower_median(st.mag);
      limit = 64'(st.tol) * 64'(r.median);
      r.accepted = (64'(m) <= limit);
    end
    return r;
  endfunction

  function automatic logic [OFS_W-1:0] signed_offset(input logic [MAG_W-1:0] m,
                                                     input logic neg);
    return neg ? -{1'b0, m} : {1'b0, m};
  endfunction

  function automatic logic [OFS_W-1:0] edge_offset(input int unsigned pick);
    case (pick)
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      default: return 32'h8000_0001;
    endcase
  endfunction

  // An offset whose magnitude sits on the threshold (variant 0), just above it
  // (1) or just below it (2). The new magnitude moves the median itself, so the
  // target is refined a few times against the window it will land in.
  function automatic logic [OFS_W-1:0] boundary_offset(input filter_state_t st,
                                                       input int variant, input logic neg);
    filter_state_t trial;
    logic [63:0] goal;
    logic [MAG_W-1:0] m;
    m = lower_median(st.mag);
    for (int i = 0; i < 3; i++) begin
      trial = st;
      trial.mag[st.slot] = m;
      goal = 64'(st.tol) * 64'(lower_median(trial.mag));
      m = (goal > 64'(MAG_MAX)) ? MAG_MAX : goal[MAG_W-1:0];
    end
    if (variant == 1 && m != MAG_MAX) m = m + MAG_W'(1);
    else if (variant == 2 && m != '0) m = m - MAG_W'(1);
    return signed_offset(m, neg);
  endfunction

  // Offsets most often cluster within the current scale, as a settled clock would
  // give. The rest are spikes, threshold hits, raw bit patterns, the extreme
  // codes and near-zero values that matter when the tolerance is zero.
  function automatic logic [OFS_W-1:0] pick_offset(input filter_state_t st);
    int unsigned roll;
    logic [63:0] spike;
    logic neg;
    roll = $urandom_range(0, 99);
    neg = 1'($urandom_range(0, 1));
    if (roll < 45) return signed_offset(31'($urandom_range(0, ofs_scale)), neg);
    if (roll < 55) begin
      spike = 64'(ofs_scale) * 64'($urandom_range(2, 40)) + 64'd1;
      return signed_offset((spike > 64'(MAG_MAX)) ? MAG_MAX : spike[MAG_W-1:0], neg);
    end
    if (roll < 70 && st.fill >= WIN - 1) return boundary_offset(st, $urandom_range(0, 2), neg);
    if (roll < 80) return $urandom;
    if (roll < 88) return edge_offset($urandom_range(0, 5));
    return signed_offset(31'($urandom_range(0, 3)), neg);
  endfunction

  // Gaps and stalls: mostly none or short, now and then a long one, and none
  // at all during calm phases.
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic int pick_pause();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  task automatic queue_offset(input logic [OFS_W-1:0] ofs);
    void'(filter_step(plan_st, ofs));
    offsets_to_send.push_back(ofs);
  endtask

  // Waits until every queued word has gone in and every result word is back.
  task automatic drain();
    while (offsets_to_send.size() != 0 || expected_verdicts.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  // The tolerance is only ever written while the block is drained.
  task automatic write_tolerance(input logic [TOL_W-1:0] t);
    @(negedge clk);
    cfg_valid <= 1'b1;
    tolerance_factor <= t;
    do @(posedge clk); while (!cfg_ready);
    model_st.tol = t;
    plan_st.tol = t;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Input side. A word that is stalled stays on the port unchanged; a new one
  // is put up only after the previous one was taken and any gap has run out.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (offsets_to_send.size() > 0) begin
        offset_value <= offsets_to_send.pop_front();
        in_valid <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side. Random stalls, plus the one long hold-off.
  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (!calm && $urandom_range(0, 99) < 20) stall_left = pick_pause();
    out_stall <= long_hold || (stall_left > 0);
  end

  // Sampling at the rising edge. The result word is checked first, then the
  // offset taken at this edge is run through the predictor. A result can never
  // come out in the cycle its own offset goes in, so the order is safe.
  always @(posedge clk) begin
    filter_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected result word accepted=%0b median=%0d full=%0b",
                                  accepted, window_median, window_full));
      end else begin
        want = expected_verdicts.pop_front();
        if (accepted !== want.accepted)
          report_mismatch($sformatf("accepted %0b, expected %0b", accepted, want.accepted));
        if (window_median !== want.median)
          report_mismatch($sformatf("window_median %0d, expected %0d",
                                    window_median, want.median));
        if (window_full !== want.full)
          report_mismatch($sformatf("window_full %0b, expected %0b", window_full, want.full));
      end
    end
    word_taken = !rst && in_valid && !in_stall;
    if (word_taken) begin
      expected_verdicts.push_back(filter_step(model_st, offset_value));
      offsets_taken++;
    end
  end

  // The long hold-off starts once the run is well under way and plenty of
  // words are still waiting, so the sender keeps offering through it.
  initial begin
    while (!(offsets_taken >= 300 && offsets_to_send.size() > 40)) @(posedge clk);
    long_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    logic [TOL_W-1:0] tol_plan [PHASES];
    tol_plan = '{4'd15, 4'd1, 4'd0, 4'd8, 4'd3, 4'd15, 4'd0, 4'd10, 4'd2, 4'd6};
    model_st = '0;
    model_st.tol = TOL_RESET;
    plan_st = model_st;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words under the reset tolerance. The first ten fill the window
    // with zero, unit and extreme magnitudes, including the most negative
    // offset; the rest run against a full window, then hit the threshold.
    queue_offset(32'h0000_0000);
    queue_offset(32'h0000_0001);
    queue_offset(32'hFFFF_FFFF);
    queue_offset(32'd100);
    queue_offset(-32'd100);
    queue_offset(32'h7FFF_FFFF);
    queue_offset(32'h8000_0000);
    queue_offset(32'h8000_0001);
    queue_offset(32'd50);
    queue_offset(-32'd50);
    queue_offset(32'h8000_0000);
    queue_offset(32'h0000_0000);
    queue_offset(32'd250);
    queue_offset(32'd100_000);
    queue_offset(32'h7FFF_FFFF);
    for (int v = 0; v < 6; v++) queue_offset(boundary_offset(plan_st, v % 3, v[0]));
    drain();

    // Random phases, one tolerance each. Two phases run with no idling on
    // either side, and the offset scale wanders so the median lags behind.
    for (int p = 0; p < PHASES; p++) begin
      write_tolerance(tol_plan[p]);
      calm = (p == 3 || p == 7);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (k % 40 == 0) ofs_scale = MAG_MAX >> $urandom_range(0, 30);
        queue_offset(pick_offset(plan_st));
      end
      drain();
    end

    // Watch a little longer for any stray result word.
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
src/mocf_pkg.sv
src/mocf_window.sv
src/mocf_select.sv
src/median_outlier_clock_filter_top.sv
sim/tb_median_outlier_clock_filter_top.sv
